// File: rtl/core/rdf_pkg.sv
`timescale 1ns / 1ps

package rdf_pkg;

  // Input word: alphabet command or number to convert
  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         symbol;
    logic signed [31:0] number;
  } in_word_t;

  // Output word: one character of the formatted text
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_word_t;

  // Item modes; the fourth code is unused and ignored
  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_APPEND  = 2'd1,
    MODE_CONVERT = 2'd2
  } mode_e;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_SIGN,
    B_DIV,
    B_READ,
    B_LOAD
  } back_state_e;

  // Alphabet store write strobe and data (address travels beside it)
  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } alpha_wr_t;

  localparam logic [7:0] SYM_LOW   = 8'd33;
  localparam logic [7:0] SYM_HIGH  = 8'd126;
  localparam logic [7:0] SYM_MINUS = 8'd45;
  localparam logic [7:0] SYM_PLUS  = 8'd43;

  localparam int unsigned NUM_W       = 32;
  localparam int unsigned DIGITS_MAX  = 32;
  localparam int unsigned DIV_BITS    = 8;
  localparam int unsigned DIV_STEPS   = NUM_W / DIV_BITS;
  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

// File: rtl/core/radix_digit_formatter.sv
`timescale 1ns / 1ps

// Formats signed 32-bit integers as text in a base set by a loaded digit
// alphabet. Words with mode clear reset the alphabet, mode append adds one
// symbol (symbols outside 33..126, '+', '-', repeats or an overflowing
// append mark the alphabet bad), and mode convert emits '-' for negative
// numbers followed by the digits from most significant down, last set on
// the final character; a bad alphabet or one with fewer than two symbols
// gives no output. Alphabet words wait until every queued conversion has
// finished. For a negative number the '-' is loaded into the output
// register first; each digit is then found in the shared divider (8
// quotient bits per cycle, 32 bits per digit), and the digits are read
// from the alphabet store and loaded into the output register in turn.
// A two-entry command queue lets new conversions be taken while one is
// being emitted.
module radix_digit_formatter #(
  parameter int unsigned MAX_SYMBOLS = 94
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rdf_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rdf_pkg::out_word_t out_word_o
);

  localparam int unsigned IW = $clog2(MAX_SYMBOLS);
  localparam int unsigned LW = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned QW = rdf_pkg::NUM_W + LW;

  logic               q_full, q_valid, q_pop, push, back_idle, drained;
  logic [QW-1:0]      push_data, q_data;
  rdf_pkg::alpha_wr_t alpha_wr;
  logic [IW-1:0]      alpha_addr;

  assign drained = back_idle && !q_valid;

  rdf_front #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .q_full_i    (q_full),
    .drained_i   (drained),
    .push_o      (push),
    .push_data_o (push_data),
    .wr_o        (alpha_wr),
    .wr_addr_o   (alpha_addr)
  );

  rdf_queue #(
    .DATA_W(QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  rdf_back #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .wr_i        (alpha_wr),
    .wr_addr_i   (alpha_addr),
    .idle_o      (back_idle),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// File: rtl/core/rdf_front.sv
`timescale 1ns / 1ps

module rdf_front #(
  parameter int unsigned MAX_SYMBOLS = 94,
  localparam int unsigned IW = $clog2(MAX_SYMBOLS),
  localparam int unsigned LW = $clog2(MAX_SYMBOLS + 1),
  localparam int unsigned QW = rdf_pkg::NUM_W + LW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rdf_pkg::in_word_t in_word_i,
  input  logic              q_full_i,
  input  logic              drained_i,
  output logic              push_o,
  output logic [QW-1:0]     push_data_o,
  output rdf_pkg::alpha_wr_t wr_o,
  output logic [IW-1:0]     wr_addr_o
);

  logic [LW-1:0] len_q, len_d;
  logic          bad_q, bad_d;
  logic [127:0]  seen_q, seen_d;

  logic is_alpha, is_conv, accept;
  logic sym_legal, sym_seen, store_full;

  // Classify the word
  assign is_alpha = (in_word_i.mode == rdf_pkg::MODE_CLEAR) ||
                    (in_word_i.mode == rdf_pkg::MODE_APPEND);
  assign is_conv  = (in_word_i.mode == rdf_pkg::MODE_CONVERT);

  // Alphabet edits wait for the back end to finish; conversions wait for queue room
  assign in_stall_o = in_valid_i && ((is_alpha && !drained_i) || (is_conv && q_full_i));
  assign accept     = in_valid_i && !in_stall_o;

  assign sym_legal  = (in_word_i.symbol inside {[rdf_pkg::SYM_LOW:rdf_pkg::SYM_HIGH]}) &&
                      (in_word_i.symbol != rdf_pkg::SYM_MINUS) &&
                      (in_word_i.symbol != rdf_pkg::SYM_PLUS);
  assign sym_seen   = seen_q[in_word_i.symbol[6:0]];
  assign store_full = (len_q >= LW'(MAX_SYMBOLS));

  // Alphabet bookkeeping and command issue
  always_comb begin
    len_d       = len_q;
    bad_d       = bad_q;
    seen_d      = seen_q;
    push_o      = 1'b0;
    push_data_o = {len_q, in_word_i.number};
    wr_o.en     = 1'b0;
    wr_o.data   = in_word_i.symbol;
    wr_addr_o   = len_q[IW-1:0];
    if (accept) begin
      case (in_word_i.mode)
        rdf_pkg::MODE_CLEAR: begin
          len_d  = '0;
          bad_d  = 1'b0;
          seen_d = '0;
        end
        rdf_pkg::MODE_APPEND: begin
          if (!sym_legal || sym_seen || store_full) begin
            bad_d = 1'b1;
          end else begin
            wr_o.en                        = 1'b1;
            seen_d[in_word_i.symbol[6:0]] = 1'b1;
            len_d                          = len_q + LW'(1);
          end
        end
        rdf_pkg::MODE_CONVERT: begin
          push_o = !bad_q && (len_q >= LW'(2));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      bad_q  <= 1'b0;
      seen_q <= '0;
    end else begin
      len_q  <= len_d;
      bad_q  <= bad_d;
      seen_q <= seen_d;
    end
  end

endmodule

// File: rtl/core/rdf_queue.sv
`timescale 1ns / 1ps

module rdf_queue #(
  parameter int unsigned DATA_W = 39,
  localparam int unsigned DEPTH = rdf_pkg::QUEUE_DEPTH,
  localparam int unsigned PW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]     cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

// File: rtl/core/rdf_back.sv
`timescale 1ns / 1ps

module rdf_back #(
  parameter int unsigned MAX_SYMBOLS = 94,
  localparam int unsigned IW = $clog2(MAX_SYMBOLS),
  localparam int unsigned LW = $clog2(MAX_SYMBOLS + 1),
  localparam int unsigned SW = IW + 1,
  localparam int unsigned QW = rdf_pkg::NUM_W + LW,
  localparam int unsigned STEP_W = $clog2(rdf_pkg::DIV_STEPS),
  localparam int unsigned CNT_W = $clog2(rdf_pkg::DIGITS_MAX + 1),
  localparam int unsigned PTR_W = $clog2(rdf_pkg::DIGITS_MAX)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  logic [QW-1:0]      q_data_i,
  output logic               q_pop_o,
  input  rdf_pkg::alpha_wr_t wr_i,
  input  logic [IW-1:0]      wr_addr_i,
  output logic               idle_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rdf_pkg::out_word_t out_word_o
);

  rdf_pkg::back_state_e state_q, state_d;

  logic [rdf_pkg::NUM_W-1:0] mag_q, mag_d;
  logic [LW-1:0]             base_q, base_d;
  logic [IW-1:0]             rem_q, rem_d;
  logic [STEP_W-1:0]         step_q, step_d;
  logic [CNT_W-1:0]          ndig_q, ndig_d;
  logic [PTR_W-1:0]          ptr_q, ptr_d;
  logic [IW-1:0]             digits_q [rdf_pkg::DIGITS_MAX];
  logic                      dig_we;

  logic [7:0]                alpha_mem [MAX_SYMBOLS];
  logic [7:0]                rd_data_q;
  logic                      rd_en;
  logic [IW-1:0]             rd_addr;

  logic                      out_valid_q, out_valid_d;
  rdf_pkg::out_word_t        out_q, out_d;
  logic                      out_load, out_free;

  logic [rdf_pkg::NUM_W-1:0] cmd_number;
  logic [LW-1:0]             cmd_base;
  logic [rdf_pkg::NUM_W-1:0] div_mag;
  logic [IW-1:0]             div_rem;
  logic [SW-1:0]             base_ext;

  assign cmd_number  = q_data_i[rdf_pkg::NUM_W-1:0];
  assign cmd_base    = q_data_i[QW-1:rdf_pkg::NUM_W];
  assign base_ext    = SW'(base_q);
  assign idle_o      = (state_q == rdf_pkg::B_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign rd_addr     = digits_q[ptr_q];

  // Eight restoring-division steps per cycle; the quotient shifts into mag
  always_comb begin
    logic [rdf_pkg::NUM_W-1:0] m;
    logic [IW-1:0]             r;
    logic [SW-1:0]             sh;
    m  = mag_q;
    r  = rem_q;
    sh = '0;
    for (int i = 0; i < rdf_pkg::DIV_BITS; i++) begin
      sh = {r, m[rdf_pkg::NUM_W-1]};
      m  = {m[rdf_pkg::NUM_W-2:0], 1'b0};
      if (sh >= base_ext) begin
        sh   = sh - base_ext;
        m[0] = 1'b1;
      end
      r = sh[IW-1:0];
    end
    div_mag = m;
    div_rem = r;
  end

  // Sequencer: sign, digit extraction, then emission most significant first
  always_comb begin
    state_d  = state_q;
    mag_d    = mag_q;
    base_d   = base_q;
    rem_d    = rem_q;
    step_d   = step_q;
    ndig_d   = ndig_q;
    ptr_d    = ptr_q;
    dig_we   = 1'b0;
    rd_en    = 1'b0;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    out_d    = out_q;
    case (state_q)
      rdf_pkg::B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          base_d  = cmd_base;
          mag_d   = cmd_number[rdf_pkg::NUM_W-1] ? ('0 - cmd_number) : cmd_number;
          rem_d   = '0;
          step_d  = '0;
          ndig_d  = '0;
          state_d = cmd_number[rdf_pkg::NUM_W-1] ? rdf_pkg::B_SIGN : rdf_pkg::B_DIV;
        end
      end
      rdf_pkg::B_SIGN: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_d.character = rdf_pkg::SYM_MINUS;
          out_d.last      = 1'b0;
          state_d         = rdf_pkg::B_DIV;
        end
      end
      rdf_pkg::B_DIV: begin
        mag_d  = div_mag;
        rem_d  = div_rem;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(rdf_pkg::DIV_STEPS - 1)) begin
          // One digit done: push the remainder, go again unless quotient is zero
          dig_we = 1'b1;
          ndig_d = ndig_q + CNT_W'(1);
          rem_d  = '0;
          step_d = '0;
          if (div_mag == '0) begin
            ptr_d   = ndig_q[PTR_W-1:0];
            state_d = rdf_pkg::B_READ;
          end
        end
      end
      rdf_pkg::B_READ: begin
        rd_en   = 1'b1;
        state_d = rdf_pkg::B_LOAD;
      end
      rdf_pkg::B_LOAD: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_d.character = rd_data_q;
          out_d.last      = (ptr_q == '0);
          if (ptr_q == '0) begin
            state_d = rdf_pkg::B_IDLE;
          end else begin
            ptr_d   = ptr_q - PTR_W'(1);
            state_d = rdf_pkg::B_READ;
          end
        end
      end
      default: state_d = rdf_pkg::B_IDLE;
    endcase
  end

  // Output register frees as soon as the word is taken
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Alphabet store: one write port from the front end, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      alpha_mem[wr_addr_i] <= wr_i.data;
    end
    if (rd_en) begin
      rd_data_q <= alpha_mem[rd_addr];
    end
  end

  // Digit stack and datapath
  always_ff @(posedge clk_i) begin
    if (dig_we) begin
      digits_q[ndig_q[PTR_W-1:0]] <= div_rem;
    end
    mag_q  <= mag_d;
    base_q <= base_d;
    rem_q  <= rem_d;
    ptr_q  <= ptr_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rdf_pkg::B_IDLE;
      step_q      <= '0;
      ndig_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      ndig_q      <= ndig_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
